>>> hw/rtl/rme_pkg.sv
// shared types and constants for the regret matching engine
`timescale 1ns / 1ps
package rme_pkg;
   localparam int MaxActions = 6;
   localparam int IdxW = 3;
   localparam int SumW = 32;
   localparam int ProbW = 17;
   localparam logic [ProbW-1:0] OneQ16 = 17'h10000;
   localparam logic [SumW-1:0] SumMax = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      FUNC_REGRET = 2'd0,
      FUNC_AVERAGE = 2'd1,
      FUNC_READ_CUR = 2'd2,
      FUNC_READ_AVG = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REGRET,
      ST_TOTAL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_APPLY,
      ST_EMIT,
      ST_STRAT
   } state_type;

   function automatic logic [ProbW-1:0] clamp_q16(input logic [ProbW-1:0] v);
      return (v > OneQ16) ? OneQ16 : v;
   endfunction
endpackage

>>> hw/rtl/rme_divider.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module rme_divider
   import rme_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SumW-1:0]     numer,
   input  logic [SumW+2:0]     denom,
   output logic                done,
   output logic [ProbW-1:0]    quot
);
   // numerator is numer * 65536; quotient never exceeds 65536 (17 bits)
   localparam int NumW = SumW + 16;
   logic [NumW-1:0] num_ff, num_in;
   logic [SumW+3:0] rem_ff, rem_in;
   logic [ProbW-1:0] q_ff, q_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [SumW+3:0] trial;

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = '0;
      if (start) begin
         num_in = {numer, 16'h0};
         rem_in = '0;
         q_in = '0;
         cnt_in = 6'(NumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff[SumW+2:0], num_ff[NumW-1]};
         num_in = {num_ff[NumW-2:0], 1'b0};
         if (trial >= {1'b0, denom}) begin
            rem_in = trial - {1'b0, denom};
            q_in = {q_ff[ProbW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[ProbW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign done = busy_ff && (cnt_ff == 6'd1);
   assign quot = q_in;
endmodule

>>> hw/rtl/regret_matching_engine.sv
// top level of the regret matching engine: sequencer, sums and output register
`timescale 1ns / 1ps
// Regret matching engine for one information set of up to six actions.
// req channel: one command per transfer; tuser carries func, tdata the six
// deltas and the three Q1.16 factors. rsp channel: for read commands, one
// transfer per action in use with its Q1.16 probability, tlast on the final
// action. csr port: csr_wen writes num_actions; the user must do so only
// while the block is idle, as the block itself does not enforce it.
// Regret update: one action per cycle through the shared multiplier, then
// back to idle. Average and read commands: a total pass over the actions,
// then per action a start step, the bit-serial divider, an apply step and
// an emit or write step; with a zero total the divider is skipped.
// req_tready is high only when the sequencer is idle. A stalled rsp side
// holds the current result in the output register and the sequencer waits.
// Reset clears both sum arrays, sets num_actions to six and empties the
// output register.
module regret_matching_engine
   import rme_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // func[1:0]
   input  logic [1:0]   req_tuser,
   // delta_0..delta_5 [32 each], regret_discount, strategy_discount,
   // reach [17 each], zero pad to 248 bits
   input  logic [247:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // action_index[2:0], probability[19:3], zero pad to 24 bits
   output logic [23:0]  rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_wen,
   input  logic [2:0]   csr_wdata
);
   state_type state_ff, state_in;
   logic [2:0] nact_ff;
   logic [SumW-1:0] regret_ff [MaxActions];
   logic [SumW-1:0] strat_ff [MaxActions];
   logic [1:0] func_ff;
   logic [SumW-1:0] delta_ff [MaxActions];
   logic [ProbW-1:0] rdisc_ff, sdisc_ff, reach_ff;
   logic [IdxW-1:0] idx_ff;
   logic [SumW+2:0] total_ff;
   logic [ProbW-1:0] prob_ff;
   logic out_v_ff;
   logic [IdxW-1:0] out_idx_ff;
   logic [ProbW-1:0] out_p_ff;
   logic out_last_ff;
   // scaled strategy sum, captured while the division result is applied
   logic [SumW-1:0] scaled_ff;

   logic [IdxW-1:0] n;
   logic last_idx;
   logic use_regret;
   logic [SumW-1:0] sel_sum;
   logic div_start, div_done;
   logic [ProbW-1:0] div_q;
   logic [SumW-1:0] mul_a;
   logic [ProbW-1:0] mul_b;
   logic [SumW+ProbW-1:0] prod;
   logic signed [SumW+2:0] rsum;
   logic [SumW+1:0] ssum;

   always_comb begin
      n = (nact_ff == 3'd0) ? 3'd1 :
          (nact_ff > 3'(MaxActions)) ? 3'(MaxActions) : nact_ff;
   end
   assign last_idx = (idx_ff == n - 3'd1);
   assign use_regret = (func_ff != FUNC_READ_AVG);
   assign sel_sum = use_regret ? regret_ff[idx_ff] : strat_ff[idx_ff];

   // shared multiplier
   always_comb begin
      mul_a = (state_ff == ST_REGRET) ? regret_ff[idx_ff] : strat_ff[idx_ff];
      mul_b = (state_ff == ST_REGRET) ? rdisc_ff : sdisc_ff;
      if (state_ff == ST_STRAT) begin
         mul_a = {15'h0, prob_ff};
         mul_b = reach_ff;
      end
      prod = mul_a * mul_b;
   end

   assign rsum = $signed({3'b000, prod[SumW+15:16]})
               + $signed({{3{delta_ff[idx_ff][SumW-1]}}, delta_ff[idx_ff]});
   // reach times probability can reach exactly one, so keep 17 bits of it
   assign ssum = {2'b00, scaled_ff} + {17'h0, prod[SumW:16]};

   assign div_start = (state_ff == ST_DIV_START) && (total_ff != '0);

   rme_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .numer(sel_sum), .denom(total_ff), .done(div_done), .quot(div_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid)
            state_in = (func_type'(req_tuser) == FUNC_REGRET) ? ST_REGRET : ST_TOTAL;
         ST_REGRET: if (last_idx) state_in = ST_IDLE;
         ST_TOTAL: if (last_idx) state_in = ST_DIV_START;
         ST_DIV_START: state_in = (total_ff == '0) ? ST_APPLY : ST_DIV_WAIT;
         ST_DIV_WAIT: if (div_done) state_in = ST_APPLY;
         ST_APPLY: state_in = (func_ff == FUNC_AVERAGE) ? ST_STRAT : ST_EMIT;
         ST_EMIT: if (!out_v_ff || rsp_tready)
            state_in = last_idx ? ST_IDLE : ST_DIV_START;
         ST_STRAT: state_in = last_idx ? ST_IDLE : ST_DIV_START;
         default: state_in = ST_IDLE;
      endcase
   end

   // uniform fallback: floor(65536 / n) via small table
   function automatic logic [ProbW-1:0] uniform_q(input logic [IdxW-1:0] k);
      unique case (k)
         3'd1: return 17'd65536;
         3'd2: return 17'd32768;
         3'd3: return 17'd21845;
         3'd4: return 17'd16384;
         3'd5: return 17'd13107;
         3'd6: return 17'd10922;
         3'd7: return 17'd9362;
         default: return 17'd65536;
      endcase
   endfunction

   // the average update needs all probabilities from the old regret sums, but
   // regret sums are not touched by it, so in-place strategy writes are safe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         nact_ff <= 3'd6;
         out_v_ff <= 1'b0;
         for (int i = 0; i < MaxActions; i++) begin
            regret_ff[i] <= '0;
            strat_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_wen) nact_ff <= csr_wdata;
         if (state_ff == ST_EMIT && (!out_v_ff || rsp_tready)) out_v_ff <= 1'b1;
         else if (rsp_tready) out_v_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               idx_ff <= '0;
               total_ff <= '0;
               if (req_tvalid) begin
                  func_ff <= req_tuser;
                  for (int i = 0; i < MaxActions; i++)
                     delta_ff[i] <= req_tdata[32*i +: 32];
                  rdisc_ff <= clamp_q16(req_tdata[192 +: 17]);
                  sdisc_ff <= clamp_q16(req_tdata[209 +: 17]);
                  reach_ff <= clamp_q16(req_tdata[226 +: 17]);
               end
            end
            ST_REGRET: begin
               if (rsum < 0) regret_ff[idx_ff] <= '0;
               else if (rsum > $signed({3'b000, SumMax})) regret_ff[idx_ff] <= SumMax;
               else regret_ff[idx_ff] <= rsum[SumW-1:0];
               idx_ff <= idx_ff + 3'd1;
            end
            ST_TOTAL: begin
               total_ff <= total_ff + {3'b000, sel_sum};
               idx_ff <= last_idx ? '0 : idx_ff + 3'd1;
            end
            ST_APPLY: begin
               prob_ff <= (total_ff == '0) ? uniform_q(n) : div_q;
            end
            ST_DIV_WAIT: ;
            ST_DIV_START: ;
            ST_EMIT: if (!out_v_ff || rsp_tready) begin
               out_idx_ff <= idx_ff;
               out_p_ff <= prob_ff;
               out_last_ff <= last_idx;
               idx_ff <= idx_ff + 3'd1;
            end
            ST_STRAT: begin
               // scaled sum plus reach times the new probability, saturated
               if (ssum > {2'b00, SumMax}) strat_ff[idx_ff] <= SumMax;
               else strat_ff[idx_ff] <= ssum[SumW-1:0];
               idx_ff <= idx_ff + 3'd1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_APPLY) scaled_ff <= prod[SumW+15:16];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = {4'h0, out_p_ff, out_idx_ff};
   assign rsp_tlast = out_last_ff;
endmodule

>>> verif/tb_top.sv
// self-checking testbench for the regret matching engine
`timescale 1ns / 1ps
module tb_top;
   import rme_pkg::*;

   typedef struct packed {
      logic [16:0] reach;
      logic [16:0] sdisc;
      logic [16:0] rdisc;
      logic [5:0][31:0] delta;
      logic [1:0] func;
   } cmd_t;

   typedef struct {
      logic [2:0] idx;
      logic [16:0] prob;
      logic last;
   } prob_t;

   localparam int WatchLimit = 4000;
   localparam int NumRandom = 320;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [1:0] req_tuser = '0;
   logic [247:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_wen = 1'b0;
   logic [2:0] csr_wdata = '0;

   cmd_t pending_cmds[$];
   prob_t expected_probs[$];
   logic [31:0] regret_shadow[MaxActions];
   logic [31:0] strat_sum[MaxActions];
   logic [2:0] act_cfg;
   logic [2:0] cfgs[8];
   logic req_fire = 1'b0;
   int errors = 0;
   int idle_cycles = 0;
   int gap_cnt = 0;
   int stall_cnt = 0;

   always #4 clock = ~clock;

   regret_matching_engine i_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tuser, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast, .csr_wen, .csr_wdata
   );

   function automatic int active_actions();
      if (act_cfg == 0) return 1;
      if (act_cfg > MaxActions) return MaxActions;
      return act_cfg;
   endfunction

   function automatic logic [16:0] sat_q16(logic [16:0] v);
      return (v > OneQ16) ? OneQ16 : v;
   endfunction

   function automatic void match_probs(input logic [31:0] s[MaxActions], input int n,
                                       output logic [16:0] p[MaxActions]);
      logic [63:0] total;
      total = 0;
      for (int i = 0; i < n; i++) total += s[i];
      for (int i = 0; i < MaxActions; i++) begin
         if (i >= n) p[i] = 0;
         else if (total == 0) p[i] = 17'(65536 / n);
         else p[i] = 17'((64'(s[i]) << 16) / total);
      end
   endfunction

   // apply one command to the shadow sums, queue any read results
   function automatic void predict_cmd(cmd_t c);
      int n;
      logic [16:0] p[MaxActions];
      logic [63:0] d, r, v;
      logic signed [64:0] sv;
      prob_t e;
      n = active_actions();
      case (func_type'(c.func))
         FUNC_REGRET: begin
            d = sat_q16(c.rdisc);
            for (int i = 0; i < n; i++) begin
               sv = $signed({1'b0, (64'(regret_shadow[i]) * d) >> 16}) +
                    $signed(c.delta[i]);
               if (sv < 0) regret_shadow[i] = 0;
               else if (sv > 65'sh0FFFF_FFFF) regret_shadow[i] = SumMax;
               else regret_shadow[i] = sv[31:0];
            end
         end
         FUNC_AVERAGE: begin
            d = sat_q16(c.sdisc);
            r = sat_q16(c.reach);
            match_probs(regret_shadow, n, p);
            for (int i = 0; i < n; i++) begin
               v = ((64'(strat_sum[i]) * d) >> 16) + ((r * p[i]) >> 16);
               strat_sum[i] = (v > 64'hFFFF_FFFF) ? SumMax : v[31:0];
            end
         end
         default: begin
            if (func_type'(c.func) == FUNC_READ_CUR) match_probs(regret_shadow, n, p);
            else match_probs(strat_sum, n, p);
            for (int i = 0; i < n; i++) begin
               e.idx = 3'(i);
               e.prob = p[i];
               e.last = (i == n - 1);
               expected_probs.insert(expected_probs.size(), e);
            end
         end
      endcase
   endfunction

   // no gap half the time, else mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_fire) begin
            void'(pending_cmds.pop_front());
            gap_cnt = pick_gap();
         end
         if (req_tvalid && !req_fire) begin
            // hold the item until the transfer happens
         end else if (gap_cnt > 0) begin
            req_tvalid <= 1'b0;
            gap_cnt = gap_cnt - 1;
         end else if (pending_cmds.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tuser <= pending_cmds[0].func;
            req_tdata <= {5'b0, pending_cmds[0].reach, pending_cmds[0].sdisc,
                          pending_cmds[0].rdisc, pending_cmds[0].delta};
         end else begin
            req_tvalid <= 1'b0;
         end
         if (stall_cnt > 0) begin
            rsp_tready <= 1'b0;
            stall_cnt <= stall_cnt - 1;
         end else begin
            rsp_tready <= 1'b1;
            stall_cnt <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      prob_t e;
      cmd_t c;
      if (!reset) begin
         req_fire <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            c.func = req_tuser;
            c.delta = req_tdata[191:0];
            c.rdisc = req_tdata[208:192];
            c.sdisc = req_tdata[225:209];
            c.reach = req_tdata[242:226];
            predict_cmd(c);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_probs.size() == 0) begin
               errors++;
               $display("%0t: unexpected result idx %0d prob %0d last %0b", $time,
                        rsp_tdata[2:0], rsp_tdata[19:3], rsp_tlast);
            end else begin
               e = expected_probs.pop_front();
               if (rsp_tdata[2:0] !== e.idx || rsp_tdata[19:3] !== e.prob ||
                   rsp_tlast !== e.last || rsp_tdata[23:20] !== 4'b0) begin
                  errors++;
                  $display("%0t: mismatch expected idx %0d prob %0d last %0b, got %0d %0d %0b",
                           $time, e.idx, e.prob, e.last, rsp_tdata[2:0],
                           rsp_tdata[19:3], rsp_tlast);
               end
            end
         end
         if (idle_cycles >= WatchLimit) begin
            $display("watchdog expired at %0t", $time);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   function automatic cmd_t make_cmd(func_type f);
      cmd_t c;
      int k;
      c.func = f;
      for (int i = 0; i < 6; i++) begin
         k = $urandom_range(0, 9);
         if (k == 0) c.delta[i] = 32'h7FFF_FFFF;
         else if (k == 1) c.delta[i] = 32'h8000_0000;
         else if (k < 5) c.delta[i] = $urandom();
         else c.delta[i] = $signed(32'($urandom_range(0, 32'h0008_0000))) -
                           32'sh0002_0000;
      end
      c.rdisc = ($urandom_range(0, 3) == 0) ? 17'($urandom()) : 17'($urandom_range(40000, 65536));
      c.sdisc = ($urandom_range(0, 3) == 0) ? 17'($urandom()) : 17'($urandom_range(40000, 65536));
      c.reach = 17'($urandom());
      return c;
   endfunction

   task automatic queue_cmd(cmd_t c);
      pending_cmds.insert(pending_cmds.size(), c);
   endtask

   // wait until every command is taken, every result seen and the block idle
   task automatic wait_drained();
      while (pending_cmds.size() > 0 || req_tvalid || expected_probs.size() > 0 ||
             !req_tready)
         @(posedge clock);
   endtask

   task automatic write_actions(logic [2:0] v);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= v;
      act_cfg = v;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   initial begin
      cmd_t c;
      cfgs = '{3'd6, 3'd1, 3'd0, 3'd7, 3'd2, 3'd5, 3'd3, 3'd4};
      act_cfg = 3'd6;
      for (int i = 0; i < MaxActions; i++) begin
         regret_shadow[i] = 0;
         strat_sum[i] = 0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: reads on zero sums, extremes of deltas and factors
      queue_cmd(make_cmd(FUNC_READ_CUR));
      queue_cmd(make_cmd(FUNC_READ_AVG));
      c = make_cmd(FUNC_REGRET);
      foreach (c.delta[i]) c.delta[i] = 32'h7FFF_FFFF;
      c.rdisc = 17'h1FFFF;
      queue_cmd(c);
      queue_cmd(c);
      queue_cmd(c);
      queue_cmd(make_cmd(FUNC_READ_CUR));
      c.func = FUNC_AVERAGE;
      c.sdisc = 17'h1FFFF;
      c.reach = 17'h1FFFF;
      for (int i = 0; i < 4; i++) queue_cmd(c);
      queue_cmd(make_cmd(FUNC_READ_AVG));
      c.func = FUNC_REGRET;
      foreach (c.delta[i]) c.delta[i] = 32'h8000_0000;
      c.rdisc = 17'h0;
      queue_cmd(c);
      c.delta[2] = 32'h0001_0000;
      c.rdisc = 17'h10000;
      queue_cmd(c);
      queue_cmd(make_cmd(FUNC_READ_CUR));
      c.func = FUNC_AVERAGE;
      c.sdisc = 17'h0;
      c.reach = 17'h0;
      queue_cmd(c);
      queue_cmd(make_cmd(FUNC_READ_AVG));
      c.delta = '1;
      c.func = FUNC_READ_AVG;
      queue_cmd(c);
      wait_drained();
      // random phases across action-count settings
      for (int ph = 0; ph < 8; ph++) begin
         write_actions(cfgs[ph]);
         for (int k = 0; k < NumRandom / 8; k++)
            queue_cmd(make_cmd(func_type'($urandom_range(0, 3))));
         wait_drained();
      end
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule

>>> regret_matching_engine.f
hw/rtl/rme_pkg.sv
hw/rtl/rme_divider.sv
hw/rtl/regret_matching_engine.sv
verif/tb_top.sv
